// ===== rtl/quaternion_to_rotation_matrix_macros.svh =====
// Assertion helpers for the quaternion to rotation matrix block.
// The enclosing module must provide clk and arst_n.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
`define QRM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qrm assertion failed");
`define QRM_ASSERT_NEXT(lbl, ante, cons) \
	`QRM_ASSERT(lbl, (ante) |=> (cons))
`else
`define QRM_ASSERT(lbl, prop)
`define QRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/qrm_pkg.sv =====
package qrm_pkg;

	localparam int N_ENT = 9;
	localparam int MAG_W = 33;
	localparam int NUM_W = 35;
	localparam int QBITS = 16;
	localparam int ONE_Q14 = 16384;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic signed [15:0] q_w;
		logic signed [15:0] q_x;
		logic signed [15:0] q_y;
		logic signed [15:0] q_z;
	} q_in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} m_out_t;

	// One division job per matrix entry, all sharing the squared norm.
	typedef struct packed {
		logic [N_ENT-1:0][MAG_W-1:0] mag;
		logic [N_ENT-1:0]            neg;
		logic [MAG_W-1:0]            den;
	} qrm_job_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} qrm_front_stat_t;

endpackage

// ===== rtl/qrm_front.sv =====
module qrm_front import qrm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  q_in_t           quat,
	output qrm_front_stat_t stat,
	output qrm_job_t        job
);

	logic                  v_s1;
	logic                  v_s2;
	logic signed [31:0]    ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0]    xy_s1, xz_s1, xw_s1, yz_s1, yw_s1, zw_s1;
	qrm_job_t              job_s2;
	logic [MAG_W-1:0]      n2;
	logic signed [NUM_W-1:0] num [N_ENT];
	qrm_job_t              job_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ww_s1 <= quat.q_w * quat.q_w;
		xx_s1 <= quat.q_x * quat.q_x;
		yy_s1 <= quat.q_y * quat.q_y;
		zz_s1 <= quat.q_z * quat.q_z;
		xy_s1 <= quat.q_x * quat.q_y;
		xz_s1 <= quat.q_x * quat.q_z;
		xw_s1 <= quat.q_x * quat.q_w;
		yz_s1 <= quat.q_y * quat.q_z;
		yw_s1 <= quat.q_y * quat.q_w;
		zw_s1 <= quat.q_z * quat.q_w;
		job_s2 <= job_nxt;
	end

	function automatic logic signed [NUM_W-1:0] sx(input logic signed [31:0] v);
		sx = NUM_W'(v);
	endfunction

	// Dividing the raw numerators by n2 equals normalizing first.
	always_comb begin
		n2 = MAG_W'(ww_s1) + MAG_W'(xx_s1) + MAG_W'(yy_s1) + MAG_W'(zz_s1);
		num[0] = sx(ww_s1) + sx(xx_s1) - sx(yy_s1) - sx(zz_s1);
		num[1] = (sx(xy_s1) - sx(zw_s1)) <<< 1;
		num[2] = (sx(xz_s1) + sx(yw_s1)) <<< 1;
		num[3] = (sx(xy_s1) + sx(zw_s1)) <<< 1;
		num[4] = sx(ww_s1) - sx(xx_s1) + sx(yy_s1) - sx(zz_s1);
		num[5] = (sx(yz_s1) - sx(xw_s1)) <<< 1;
		num[6] = (sx(xz_s1) - sx(yw_s1)) <<< 1;
		num[7] = (sx(yz_s1) + sx(xw_s1)) <<< 1;
		num[8] = sx(ww_s1) - sx(xx_s1) - sx(yy_s1) + sx(zz_s1);
		job_nxt.den = n2;
		for (int i = 0; i < N_ENT; i++) begin
			job_nxt.neg[i] = num[i][NUM_W-1];
			job_nxt.mag[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
		end
		// A zero quaternion becomes 1/1 on the diagonal, giving the identity.
		if (n2 == '0) begin
			job_nxt.den = MAG_W'(1);
			for (int i = 0; i < N_ENT; i++) begin
				job_nxt.neg[i] = 1'b0;
				job_nxt.mag[i] = (i % 4 == 0) ? MAG_W'(1) : '0;
			end
		end
	end

	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;
	assign job = job_s2;

endmodule

// ===== rtl/qrm_queue.sv =====
module qrm_queue import qrm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  qrm_job_t                   wr_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       rd_valid,
	output qrm_job_t                   rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	qrm_job_t        mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            rd_valid_q;
	qrm_job_t        rd_data_q;
	logic            pop;

	// The back end never stalls, so any held entry leaves the next cycle.
	assign pop = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= pop;
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
		if (pop)
			rd_data_q <= mem[rd_ptr_q];
	end

	assign count    = count_q;
	assign rd_valid = rd_valid_q;
	assign rd_data  = rd_data_q;

endmodule

// ===== rtl/qrm_div_lane.sv =====
module qrm_div_lane import qrm_pkg::*; (
	input  logic                clk,
	input  logic [MAG_W-1:0]    mag,
	input  logic [MAG_W-1:0]    den,
	input  logic                neg,
	output logic signed [15:0]  res
);

	logic [MAG_W-1:0] rem_s [QBITS];
	logic [MAG_W-1:0] den_s [QBITS];
	logic [QBITS-1:0] quo_s [QBITS];
	logic             neg_s [QBITS];
	logic [QBITS:0]   rnd;
	logic [15:0]      q;
	logic signed [15:0] res_q;

	// One quotient bit per stage: quo = floor(mag * 2^15 / den).
	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic [MAG_W:0]   shifted;
		logic [MAG_W-1:0] d_in;
		logic [QBITS-1:0] q_in;
		logic             n_in;
		logic             ge;
		logic [QBITS-1:0] q_nxt;
		logic [MAG_W:0]   diff;

		if (k == 0) begin : g_first
			assign shifted = {1'b0, mag};
			assign d_in    = den;
			assign q_in    = '0;
			assign n_in    = neg;
		end else begin : g_rest
			assign shifted = {rem_s[k-1], 1'b0};
			assign d_in    = den_s[k-1];
			assign q_in    = quo_s[k-1];
			assign n_in    = neg_s[k-1];
		end

		assign ge   = (shifted >= {1'b0, d_in});
		assign diff = shifted - {1'b0, d_in};

		always_comb begin
			q_nxt = q_in;
			q_nxt[QBITS-1-k] = ge;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
			den_s[k] <= d_in;
			quo_s[k] <= q_nxt;
			neg_s[k] <= n_in;
		end
	end

	// Round half away from zero: (quo + 1) / 2.
	assign rnd = {1'b0, quo_s[QBITS-1]} + (QBITS+1)'(1);
	assign q   = rnd[QBITS:1];

	always_ff @(posedge clk) begin
		res_q <= neg_s[QBITS-1] ? -$signed(q) : $signed(q);
	end

	assign res = res_q;

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Quaternion (w, x, y, z) in signed Q4.12 to the 3x3 rotation matrix of the
// normalized quaternion, nine entries in signed Q2.14, rounded to nearest.
//
// Input: present a quaternion on quat and raise start; it is taken at any
// rising edge where start is high and busy is low. Output: each matrix is on
// mat for one cycle with strobe high.
// The receiver cannot stall; results must be captured when strobe is high.
//
// Throughput is one quaternion per cycle while busy is low. The front end
// forms the ten pairwise products and the numerators, a small queue
// follows, and the back end runs nine pipelined dividers that retire one
// quotient bit per stage, sixteen stages deep. busy rises only if the
// queue plus the items in the front end could exceed its depth.
//
// Reset clears all valid flags and the queue; data registers are not reset.
// A zero quaternion produces the identity matrix.
module quaternion_to_rotation_matrix import qrm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  q_in_t  quat,
	output logic   strobe,
	output m_out_t mat
);

`include "quaternion_to_rotation_matrix_macros.svh"

	localparam int CW = $clog2(QUEUE_DEPTH+1);
	localparam int LATENCY = QBITS + 5;

	qrm_front_stat_t       fstat;
	qrm_job_t              front_job;
	logic [CW-1:0]         q_count;
	logic                  q_valid;
	qrm_job_t              q_job;
	logic                  accept;
	logic [CW+1:0]         held;
	logic [QBITS:0]        vld_q;
	logic signed [15:0]    res [N_ENT];
	logic                  ident_out;

	assign accept = start && !busy;
	assign held   = (CW+2)'(q_count) + (CW+2)'(fstat.v_s1) + (CW+2)'(fstat.v_s2);
	assign busy   = (held >= (CW+2)'(QUEUE_DEPTH));

	qrm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.quat   (quat),
		.stat   (fstat),
		.job    (front_job)
	);

	qrm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fstat.v_s2),
		.wr_data  (front_job),
		.count    (q_count),
		.rd_valid (q_valid),
		.rd_data  (q_job)
	);

	for (genvar i = 0; i < N_ENT; i++) begin : g_lane
		qrm_div_lane u_lane (
			.clk (clk),
			.mag (q_job.mag[i]),
			.den (q_job.den),
			.neg (q_job.neg[i]),
			.res (res[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[QBITS-1:0], q_valid};
	end

	assign strobe  = vld_q[QBITS];
	assign mat.m00 = res[0];
	assign mat.m01 = res[1];
	assign mat.m02 = res[2];
	assign mat.m10 = res[3];
	assign mat.m11 = res[4];
	assign mat.m12 = res[5];
	assign mat.m20 = res[6];
	assign mat.m21 = res[7];
	assign mat.m22 = res[8];

	assign ident_out = strobe && (mat.m00 == 16'sd16384) && (mat.m01 == '0)
		&& (mat.m11 == 16'sd16384);

	`QRM_ASSERT(a_queue_no_overflow, fstat.v_s2 |-> (q_count != CW'(QUEUE_DEPTH)))
	`QRM_ASSERT(a_fixed_latency, accept |-> ##LATENCY strobe)
	`QRM_ASSERT_NEXT(a_strobe_has_source, !vld_q[QBITS-1], !strobe)
	`QRM_ASSERT(a_zero_is_identity, (accept && quat == '0) |-> ##LATENCY ident_out)

endmodule
